// ===== sv/ufc_pkg.sv =====
`timescale 1ns / 1ps

package ufc_pkg;

  // Longest frame that is checked and summed; longer frames fail the length check.
  localparam int unsigned MaxFrameBytes = 2048;
  // Head, sync, feature, id, length, checksum and the two end bytes.
  localparam int unsigned MinFrameBytes = 11;
  // First payload position.
  localparam int unsigned HeaderBytes   = 8;

  localparam int unsigned CountW   = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic KindPayload = 1'b0;
  localparam logic KindVerdict = 1'b1;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_SHORT        = 3'd1,
    ST_BAD_HEAD     = 3'd2,
    ST_BAD_END      = 3'd3,
    ST_LEN_MISMATCH = 3'd4,
    ST_BAD_SYNC     = 3'd5
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEAD       = 3'd0,
    CFG_END_FIRST  = 3'd1,
    CFG_END_SECOND = 3'd2,
    CFG_SYNC_IN    = 3'd3,
    CFG_SYNC_OUT   = 3'd4,
    CFG_REQ_FEAT   = 3'd5,
    CFG_REQ_CMD    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]  head;
    logic [7:0]  end_first;
    logic [7:0]  end_second;
    logic [7:0]  sync_in;
    logic [7:0]  sync_out;
    logic [15:0] req_feature;
    logic [15:0] req_command;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    head:        8'h00,
    end_first:   8'h00,
    end_second:  8'h00,
    sync_in:     8'h00,
    sync_out:    8'hBA,
    req_feature: 16'hFF01,
    req_command: 16'h0117
  };

  // Fields captured from the frame so far.
  typedef struct packed {
    logic [7:0]  first_byte;
    logic [7:0]  sync;
    logic [15:0] feature;
    logic [15:0] command;
    logic [15:0] length;
    logic [7:0]  sum;
    logic [7:0]  cks;
    logic [7:0]  first_payload;
  } frame_t;

  typedef struct packed {
    status_e    status;
    logic       checksum_ok;
    logic       local_req;
    logic [7:0] wheel;
  } verdict_t;

endpackage

// ===== sv/ufc_in_if.sv =====
`timescale 1ns / 1ps

interface ufc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

// ===== sv/ufc_out_if.sv =====
`timescale 1ns / 1ps

interface ufc_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  payload_byte;
  logic [2:0]  status;
  logic [7:0]  sync_value;
  logic [15:0] feature_code;
  logic [15:0] command_id;
  logic [15:0] payload_length;
  logic        checksum_ok;
  logic        local_request;
  logic [7:0]  wheel_index;

  modport source (
    output valid, output kind, output payload_byte, output status, output sync_value,
    output feature_code, output command_id, output payload_length, output checksum_ok,
    output local_request, output wheel_index, input ready
  );
  modport sink (
    input valid, input kind, input payload_byte, input status, input sync_value,
    input feature_code, input command_id, input payload_length, input checksum_ok,
    input local_request, input wheel_index, output ready
  );
endinterface

// ===== sv/uart_frame_checker.sv =====
`timescale 1ns / 1ps

// Streaming checker for byte frames of the form
//   head, sync, feature (2), id (2), length L (2), payload (L), checksum, end (2),
// all multi-byte fields big-endian.
// Bytes enter on in_i, one word per byte, with final_byte set on the last byte of
// a frame. Each payload byte that is not the final byte leaves on out_o as a word
// of kind 0. The final byte produces one verdict word of kind 1 with the status,
// the captured header fields, the checksum match and the local sensor request flag
// with its wheel index; the frame state is then cleared for the next frame.
// Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i and
// must only change while no frame is in flight.
// Each result word is registered in the cycle after its byte is accepted. One byte is
// accepted every cycle while in_i.ready is high: all the per-byte work (header capture,
// 8-bit running sum, length compare and the verdict) fits between the frame registers
// and the output register. The output register holds one word; while it is full and
// out_o.ready is low, in_i.ready drops, so a stalled receiver holds the whole stream
// without losing a word. Bytes that produce no word still need the output register free.
// Reset clears the frame state, empties the output register and loads the
// register defaults.

module uart_frame_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ufc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [ufc_pkg::CfgDataW-1:0]   cfg_wdata_i,
  ufc_in_if.sink                         in_i,
  ufc_out_if.source                      out_o
);
  import ufc_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    status_e     status;
    logic [7:0]  sync;
    logic [15:0] feature;
    logic [15:0] command;
    logic [15:0] length;
    logic        checksum_ok;
    logic        local_req;
    logic [7:0]  wheel;
  } res_t;

  cfg_t              cfg_q;
  frame_t            frame_q, frame_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [7:0]        prev_q, prev_d;
  res_t              res_q, res_d;
  logic              vld_q, vld_d;

  logic [CountW:0]   body_end;
  logic              fwd;
  logic              in_acc;
  logic              load;
  logic [7:0]        b;
  verdict_t          verdict;

  assign b      = in_i.data_byte;
  assign in_acc = in_i.valid && in_i.ready;
  assign in_i.ready = !vld_q || out_o.ready;

  // Configuration registers; an index past the last register is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HEAD:       cfg_q.head        <= cfg_wdata_i[7:0];
        CFG_END_FIRST:  cfg_q.end_first   <= cfg_wdata_i[7:0];
        CFG_END_SECOND: cfg_q.end_second  <= cfg_wdata_i[7:0];
        CFG_SYNC_IN:    cfg_q.sync_in     <= cfg_wdata_i[7:0];
        CFG_SYNC_OUT:   cfg_q.sync_out    <= cfg_wdata_i[7:0];
        CFG_REQ_FEAT:   cfg_q.req_feature <= cfg_wdata_i;
        CFG_REQ_CMD:    cfg_q.req_command <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Header capture and checksum accumulation for the byte on the input.
  // The body end uses the length as stored before this byte.
  always_comb begin
    frame_d  = frame_q;
    fwd      = 1'b0;
    body_end = (CountW+1)'(HeaderBytes) + {1'b0, frame_q.length};
    if (cnt_q < CountW'(MaxFrameBytes)) begin
      case (cnt_q)
        16'd0: frame_d.first_byte = b;
        16'd1: frame_d.sync       = b;
        16'd2: frame_d.feature    = {b, 8'h00};
        16'd3: frame_d.feature    = {frame_q.feature[15:8], b};
        16'd4: frame_d.command    = {b, 8'h00};
        16'd5: frame_d.command    = {frame_q.command[15:8], b};
        16'd6: frame_d.length     = {b, 8'h00};
        16'd7: frame_d.length     = {frame_q.length[15:8], b};
        default: begin
        end
      endcase
      if ({1'b0, cnt_q} < body_end) begin
        frame_d.sum = frame_q.sum + b;
        if (cnt_q >= CountW'(HeaderBytes)) begin
          if (cnt_q == CountW'(HeaderBytes)) begin
            frame_d.first_payload = b;
          end
          fwd = 1'b1;
        end
      end else if ({1'b0, cnt_q} == body_end) begin
        frame_d.cks = b;
      end
    end
  end

  ufc_verdict u_verdict (
    .cfg_i       (cfg_q),
    .frame_i     (frame_d),
    .count_i     (cnt_q),
    .prev_byte_i (prev_q),
    .last_byte_i (b),
    .verdict_o   (verdict)
  );

  // Next frame state: the final byte clears everything, other bytes advance.
  always_comb begin
    cnt_d  = cnt_q;
    prev_d = prev_q;
    if (in_i.final_byte) begin
      cnt_d  = '0;
      prev_d = 8'h00;
    end else begin
      prev_d = b;
      if (cnt_q != '1) begin
        cnt_d = cnt_q + CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      prev_q  <= 8'h00;
      frame_q <= '0;
    end else if (in_acc) begin
      cnt_q   <= cnt_d;
      prev_q  <= prev_d;
      frame_q <= in_i.final_byte ? '0 : frame_d;
    end
  end

  // Result word and output register.
  always_comb begin
    res_d = '0;
    if (in_i.final_byte) begin
      res_d.kind        = KindVerdict;
      res_d.status      = verdict.status;
      res_d.sync        = frame_d.sync;
      res_d.feature     = frame_d.feature;
      res_d.command     = frame_d.command;
      res_d.length      = frame_d.length;
      res_d.checksum_ok = verdict.checksum_ok;
      res_d.local_req   = verdict.local_req;
      res_d.wheel       = verdict.wheel;
    end else begin
      res_d.kind         = KindPayload;
      res_d.payload_byte = b;
    end
  end

  assign load = in_acc && (in_i.final_byte || fwd);

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (out_o.ready) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid          = vld_q;
  assign out_o.kind           = res_q.kind;
  assign out_o.payload_byte   = res_q.payload_byte;
  assign out_o.status         = res_q.status;
  assign out_o.sync_value     = res_q.sync;
  assign out_o.feature_code   = res_q.feature;
  assign out_o.command_id     = res_q.command;
  assign out_o.payload_length = res_q.length;
  assign out_o.checksum_ok    = res_q.checksum_ok;
  assign out_o.local_request  = res_q.local_req;
  assign out_o.wheel_index    = res_q.wheel;

  // A final byte always leaves the frame state empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.final_byte |=> cnt_q == '0 && frame_q == '0)
    else $error("frame state not cleared after final byte");

  // A non-final byte advances the count unless it has saturated.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !in_i.final_byte && cnt_q != '1 |=> cnt_q == $past(cnt_q) + CountW'(1))
    else $error("byte count did not advance");

  // A final byte yields a verdict word in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.final_byte |=> vld_q && res_q.kind == KindVerdict)
    else $error("missing verdict word");

  // A local request needs a passing frame with a good checksum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && res_q.local_req |-> res_q.checksum_ok && res_q.status == ST_OK)
    else $error("local request on a failed frame");

  // A full output register that is not drained blocks the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && !out_o.ready |-> !in_i.ready)
    else $error("input taken while the output is stalled");

endmodule

// ===== sv/ufc_verdict.sv =====
`timescale 1ns / 1ps

module ufc_verdict (
  input  ufc_pkg::cfg_t                 cfg_i,
  input  ufc_pkg::frame_t               frame_i,
  input  logic [ufc_pkg::CountW-1:0]    count_i,
  input  logic [7:0]                    prev_byte_i,
  input  logic [7:0]                    last_byte_i,
  output ufc_pkg::verdict_t             verdict_o
);
  import ufc_pkg::*;

  logic [CountW:0] frame_len;
  logic [CountW:0] expect_len;
  status_e         status;
  logic            sum_match;
  logic            is_ok;
  logic            req_hit;

  always_comb begin
    // The final byte itself is not yet in the count.
    frame_len  = {1'b0, count_i} + (CountW+1)'(1);
    expect_len = (CountW+1)'(MinFrameBytes) + {1'b0, frame_i.length};

    if (frame_len < (CountW+1)'(MinFrameBytes)) begin
      status = ST_SHORT;
    end else if (frame_i.first_byte != cfg_i.head) begin
      status = ST_BAD_HEAD;
    end else if (prev_byte_i != cfg_i.end_first || last_byte_i != cfg_i.end_second) begin
      status = ST_BAD_END;
    end else if (frame_len > (CountW+1)'(MaxFrameBytes) || frame_len != expect_len) begin
      status = ST_LEN_MISMATCH;
    end else if (frame_i.sync != cfg_i.sync_in && frame_i.sync != cfg_i.sync_out) begin
      status = ST_BAD_SYNC;
    end else begin
      status = ST_OK;
    end

    is_ok     = (status == ST_OK);
    // The checksum byte is the negated 8-bit sum of everything before it.
    sum_match = ((8'h00 - frame_i.sum) == frame_i.cks);
    req_hit   = (frame_i.command == cfg_i.req_command) &&
                (frame_i.feature == cfg_i.req_feature) &&
                (frame_i.sync == cfg_i.sync_in) && (frame_i.length != 16'h0000);

    verdict_o.status      = status;
    verdict_o.checksum_ok = is_ok && sum_match;
    verdict_o.local_req   = is_ok && sum_match && req_hit;
    verdict_o.wheel       = (is_ok && sum_match && req_hit) ? frame_i.first_payload : 8'h00;
  end

endmodule
